// File: src/assert_macros.svh
// Assertion macros for the port-level checker of the indexed list queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ILQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("indexed list queue check failed");

// Consequent in the cycle after the antecedent.
`define ILQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("indexed list queue check failed");

// Consequent delayed after the antecedent.
`define ILQ_ASSERT_DLY2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("indexed list queue check failed");

`endif

// File: src/ilq_pkg.sv
// Types and constants shared by the indexed list queue modules.
package ilq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 5;
  localparam int OIDX_W = 4;
  localparam int OCNT_W = 5;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_TRAVERSE = 3'd2,
    CMD_INSERT   = 3'd3,
    CMD_REMOVE   = 3'd4,
    CMD_REVERSE  = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the accepted item
    logic exec;  // carry out a single-result command
    logic trav;  // emit one traversal result
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trav_last;  // the traversal result now being emitted is the final one
  } stat_t;

endpackage

// File: src/ilq_ctrl.sv
// Controller state machine of the indexed list queue.
module ilq_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ilq_pkg::CMD_W-1:0]         cmd_i,
  input  ilq_pkg::stat_t                    stat_i,
  output ilq_pkg::ctrl_t                    ctrl_o,
  output logic                              busy_o
);
  import ilq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TRAV
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_PUSH, CMD_POP, CMD_INSERT, CMD_REMOVE, CMD_REVERSE: state_d = S_EXEC;
            CMD_TRAVERSE: state_d = S_TRAV;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EXEC: state_d = S_IDLE;
      S_TRAV: begin
        if (stat_i.trav_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_o  <= (state_d != S_IDLE);
    end
  end

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == S_EXEC);
  assign ctrl_o.trav = (state_q == S_TRAV);

endmodule

// File: src/ilq_dp.sv
// Datapath of the indexed list queue: entry cells, count, orientation and result registers.
module ilq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ilq_pkg::ctrl_t                        ctrl_i,
  output ilq_pkg::stat_t                        stat_o,
  input  logic [ilq_pkg::CMD_W-1:0]             cmd_i,
  input  logic [ilq_pkg::POS_W-1:0]             position_i,
  input  logic signed [ilq_pkg::DATA_W-1:0]     value_i,
  output logic                                  out_valid_o,
  output logic signed [ilq_pkg::DATA_W-1:0]     out_value_o,
  output logic [ilq_pkg::OIDX_W-1:0]            out_index_o,
  output logic [ilq_pkg::STAT_W-1:0]            status_o,
  output logic                                  last_o,
  output logic [ilq_pkg::OCNT_W-1:0]            count_o
);
  import ilq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic signed [DATA_W-1:0] cells_q [DEPTH];
  logic signed [DATA_W-1:0] cells_d [DEPTH];
  logic [CW-1:0]            count_q, count_d;
  logic                     rev_q, rev_d;
  cmd_e                     cmd_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] val_q;
  logic [IW-1:0]            trav_q;

  logic                     res_valid_q;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;
  logic [OIDX_W-1:0]        res_index_q, res_index_d;
  status_e                  res_status_q, res_status_d;
  logic                     res_last_q, res_last_d;

  logic [PW-1:0]            n_w, pos_w, lidx, base, phys_w;
  logic [IW-1:0]            phys;
  logic signed [DATA_W-1:0] rd;
  logic                     empty, full, is_ins, do_ins, do_rem, emit;

  assign n_w   = PW'(count_q);
  assign pos_w = PW'(pos_q);
  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));

  // Logical index of the current access and whether it opens a gap.
  always_comb begin
    is_ins = 1'b0;
    lidx   = '0;
    case (cmd_q)
      CMD_PUSH: begin
        is_ins = 1'b1;
        lidx   = n_w;
      end
      CMD_INSERT: begin
        is_ins = 1'b1;
        lidx   = pos_w;
      end
      CMD_REMOVE:   lidx = pos_w;
      CMD_TRAVERSE: lidx = PW'(trav_q);
      default:      lidx = '0;
    endcase
  end

  // When the list is held reversed, logical index L lives at physical n-1-L,
  // and a gap opened at L lands at physical n-L.
  assign base   = is_ins ? n_w : (n_w - PW'(1));
  assign phys_w = rev_q ? (base - lidx) : lidx;
  assign phys   = phys_w[IW-1:0];
  assign rd     = cells_q[phys];

  assign stat_o.trav_last = empty || (PW'(trav_q) == (n_w - PW'(1)));

  always_comb begin
    do_ins       = 1'b0;
    do_rem       = 1'b0;
    rev_d        = rev_q;
    emit         = 1'b0;
    res_value_d  = '0;
    res_index_d  = '0;
    res_status_d = ST_OK;
    res_last_d   = 1'b1;
    if (ctrl_i.exec) begin
      emit = 1'b1;
      case (cmd_q)
        CMD_PUSH: begin
          if (full) res_status_d = ST_FULL;
          else      do_ins = 1'b1;
        end
        CMD_POP: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            do_rem      = 1'b1;
            res_value_d = rd;
          end
        end
        CMD_INSERT: begin
          if (full)              res_status_d = ST_FULL;
          else if (pos_w > n_w)  res_status_d = ST_BADPOS;
          else                   do_ins = 1'b1;
        end
        CMD_REMOVE: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else if (pos_w >= n_w) begin
            res_status_d = ST_BADPOS;
          end else begin
            do_rem      = 1'b1;
            res_value_d = rd;
          end
        end
        CMD_REVERSE: begin
          if (empty) res_status_d = ST_EMPTY;
          else       rev_d = ~rev_q;
        end
        default: emit = 1'b0;
      endcase
    end else if (ctrl_i.trav) begin
      emit = 1'b1;
      if (empty) begin
        res_status_d = ST_EMPTY;
      end else begin
        res_value_d = rd;
        res_index_d = OIDX_W'(trav_q);
        res_last_d  = stat_o.trav_last;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins)      count_d = count_q + CW'(1);
    else if (do_rem) count_d = count_q - CW'(1);
  end

  // Each cell takes its lower neighbor, its upper neighbor, the new value, or holds.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IW-1:0] ME = IW'(i);
    always_comb begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        if (ME == phys) begin
          cells_d[i] = val_q;
        end else if (ME > phys) begin
          if (i > 0) cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if (ME >= phys) begin
          if (i < DEPTH - 1) cells_d[i] = cells_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (ctrl_i.load) begin
      pos_q <= position_i;
      val_q <= value_i;
    end
    res_value_q  <= res_value_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rev_q       <= 1'b0;
      cmd_q       <= CMD_PUSH;
      trav_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rev_q       <= rev_d;
      res_valid_q <= emit;
      if (ctrl_i.load) begin
        cmd_q  <= cmd_e'(cmd_i);
        trav_q <= '0;
      end else if (ctrl_i.trav) begin
        trav_q <= trav_q + IW'(1);
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_value_o = res_value_q;
  assign out_index_o = res_index_q;
  assign status_o    = res_status_q;
  assign last_o      = res_last_q;
  assign count_o     = OCNT_W'(count_q);

endmodule

// File: src/indexed_list_queue.sv
// Top level of the indexed list queue: controller and datapath.
//
// An ordered list of up to DEPTH signed 32-bit entries driven by one command per item:
// push, pop, traverse, insert at, remove at and reverse. An item is taken at a rising
// edge where start_i is high and busy_o is low. Every command but traverse returns one
// status result once it is taken: the command is carried out in the execute state and
// the result is then presented from a register. Traverse returns one result per entry,
// in list order, one per cycle (one empty status for an empty list), and keeps the
// block busy until its final result. Each result shows for exactly one cycle with
// out_valid_o high; the receiver cannot hold it off, so it must take every result as
// it comes. last_o marks the final result of a command, and count_o gives the number
// of entries after the command. The entries sit in a row of cells that shift by one
// place for insert and remove; reverse only flips an orientation bit. Unused command
// codes are taken and ignored. A new item may be taken while the previous result is
// still showing.
module indexed_list_queue #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [ilq_pkg::CMD_W-1:0]             cmd_i,
  input  logic [ilq_pkg::POS_W-1:0]             position_i,
  input  logic signed [ilq_pkg::DATA_W-1:0]     value_i,
  output logic                                  out_valid_o,
  output logic signed [ilq_pkg::DATA_W-1:0]     out_value_o,
  output logic [ilq_pkg::OIDX_W-1:0]            out_index_o,
  output logic [ilq_pkg::STAT_W-1:0]            status_o,
  output logic                                  last_o,
  output logic [ilq_pkg::OCNT_W-1:0]            count_o
);
  import ilq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // The controller sequences each item; it sees the command code and the traversal status.
  ilq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  // The datapath holds the entries and forms every result.
  ilq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_value_o (out_value_o),
    .out_index_o (out_index_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .count_o     (count_o)
  );

endmodule

// File: src/ilq_checker.sv
// Port-level checker for the indexed list queue, bound to the top level.
`include "assert_macros.svh"

module ilq_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start_i,
  input logic                                  busy_o,
  input logic [ilq_pkg::CMD_W-1:0]             cmd_i,
  input logic                                  out_valid_o,
  input logic [ilq_pkg::STAT_W-1:0]            status_o,
  input logic                                  last_o
);
  import ilq_pkg::*;

  logic take, single, known;

  assign take   = start_i && !busy_o;
  assign single = (cmd_i == CMD_PUSH) || (cmd_i == CMD_POP) || (cmd_i == CMD_INSERT) ||
                  (cmd_i == CMD_REMOVE) || (cmd_i == CMD_REVERSE);
  assign known  = single || (cmd_i == CMD_TRAVERSE);

  // A single-result command is answered by one result marked last.
  `ILQ_ASSERT_DLY2(a_single_result, take && single, out_valid_o && last_o)
  // An unknown command causes no result.
  `ILQ_ASSERT_DLY2(a_unknown_silent, take && !known, !out_valid_o)
  // Any status other than ok ends its command.
  `ILQ_ASSERT_NOW(a_error_is_last, out_valid_o && (status_o != ST_OK), last_o)
  // Traversal results come back to back until the last one.
  `ILQ_ASSERT_NEXT(a_trav_stream, out_valid_o && !last_o, out_valid_o)

endmodule

bind indexed_list_queue ilq_checker u_ilq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .status_o    (status_o),
  .last_o      (last_o)
);

// File: test/indexed_list_queue_checker.sv
// Checker that predicts the indexed list queue results and compares them with the ports.
module indexed_list_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_o,
  input  logic [ilq_pkg::CMD_W-1:0]             cmd_i,
  input  logic [ilq_pkg::POS_W-1:0]             position_i,
  input  logic signed [ilq_pkg::DATA_W-1:0]     value_i,
  input  logic                                  out_valid_o,
  input  logic signed [ilq_pkg::DATA_W-1:0]     out_value_o,
  input  logic [ilq_pkg::OIDX_W-1:0]            out_index_o,
  input  logic [ilq_pkg::STAT_W-1:0]            status_o,
  input  logic                                  last_o,
  input  logic [ilq_pkg::OCNT_W-1:0]            count_o,
  output int                                    mismatch_count_o,
  output int                                    awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ilq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [OIDX_W-1:0]        index;
    status_e                  status;
    logic                     last;
    logic [OCNT_W-1:0]        count;
  } list_result_t;

  // Entry 0 is the head of the list.
  logic signed [DATA_W-1:0] shadow_list[$];
  list_result_t             awaited_results[$];
  int                       mismatches;

  function automatic void post_result(logic signed [DATA_W-1:0] v, int idx, status_e st,
                                      logic lst);
    list_result_t r;
    r.value  = v;
    r.index  = OIDX_W'(idx);
    r.status = st;
    r.last   = lst;
    r.count  = OCNT_W'(shadow_list.size());
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_list_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] val);
    int                       n;
    int                       p;
    logic signed [DATA_W-1:0] taken;
    logic signed [DATA_W-1:0] swap;
    n = shadow_list.size();
    p = int'(pos);
    case (cmd)
      CMD_PUSH: begin
        if (n >= DEPTH) begin
          post_result('0, 0, ST_FULL, 1'b1);
        end else begin
          shadow_list.push_back(val);
          post_result('0, 0, ST_OK, 1'b1);
        end
      end
      CMD_POP: begin
        if (n == 0) begin
          post_result('0, 0, ST_EMPTY, 1'b1);
        end else begin
          taken = shadow_list.pop_front();
          post_result(taken, 0, ST_OK, 1'b1);
        end
      end
      CMD_TRAVERSE: begin
        if (n == 0) begin
          post_result('0, 0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            post_result(shadow_list[i], i, ST_OK, i == n - 1);
          end
        end
      end
      CMD_INSERT: begin
        // A full list is reported before a bad position.
        if (n >= DEPTH) begin
          post_result('0, 0, ST_FULL, 1'b1);
        end else if (p > n) begin
          post_result('0, 0, ST_BADPOS, 1'b1);
        end else begin
          shadow_list.insert(p, val);
          post_result('0, 0, ST_OK, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (n == 0) begin
          post_result('0, 0, ST_EMPTY, 1'b1);
        end else if (p >= n) begin
          post_result('0, 0, ST_BADPOS, 1'b1);
        end else begin
          taken = shadow_list[p];
          shadow_list.delete(p);
          post_result(taken, 0, ST_OK, 1'b1);
        end
      end
      CMD_REVERSE: begin
        if (n == 0) begin
          post_result('0, 0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n / 2; i++) begin
            swap               = shadow_list[i];
            shadow_list[i]     = shadow_list[n-1-i];
            shadow_list[n-1-i] = swap;
          end
          post_result('0, 0, ST_OK, 1'b1);
        end
      end
      default: begin
        // The two unused codes leave the list alone and give nothing.
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    if (!rst_ni) begin
      shadow_list.delete();
      awaited_results.delete();
      mismatches = 0;
    end else begin
      // Results are compared before the item of this edge is predicted, since
      // an item never produces a result at the edge that takes it.
      if (out_valid_o) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected result value %0d index %0d status %0d last %0b count %0d",
                     $realtime, out_value_o, out_index_o, status_o, last_o, count_o);
          end
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_value_o !== exp_r.value || out_index_o !== exp_r.index ||
              status_o !== exp_r.status || last_o !== exp_r.last ||
              count_o !== exp_r.count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch, expected value %0d index %0d status %0d",
                       $realtime, exp_r.value, exp_r.index, exp_r.status);
              $display("  last %0b count %0d, got value %0d index %0d status %0d",
                       exp_r.last, exp_r.count, out_value_o, out_index_o, status_o);
              $display("  got last %0b count %0d", last_o, count_o);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_list_command(cmd_i, position_i, value_i);
      end
    end
    mismatch_count_o = mismatches;
    awaited_count_o  = awaited_results.size();
  end

endmodule

// File: test/indexed_list_queue_tb.sv
// Testbench top for the indexed list queue: clock, reset, command stimulus and verdict.
module indexed_list_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int ITEMS_PER_RUN = 200;
  localparam int PHASE_COUNT   = 4;

  // The two command codes that the block takes and ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] DATA_NEG = -32'sd1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Every input starts at a known value, so the block never sees an unknown.
  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start_i    = 1'b0;
  logic [CMD_W-1:0]         cmd_i      = CMD_PUSH;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] value_i    = '0;

  logic                     busy_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic [OIDX_W-1:0]        out_index_o;
  logic [STAT_W-1:0]        status_o;
  logic                     last_o;
  logic [OCNT_W-1:0]        count_o;

  int mismatch_count;
  int awaited_count;

  // Chance, in percent, that the sender idles for another cycle before an item.
  int idle_pct;

  // Rough length of the list as the stimulus sees it. It only steers the choice of
  // commands and positions toward the interesting corners; all checking is done
  // by the checker.
  int list_len;

  indexed_list_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_value_o(out_value_o),
    .out_index_o(out_index_o),
    .status_o   (status_o),
    .last_o     (last_o),
    .count_o    (count_o)
  );

  indexed_list_queue_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_value_o     (out_value_o),
    .out_index_o     (out_index_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .count_o         (count_o),
    .mismatch_count_o(mismatch_count),
    .awaited_count_o (awaited_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hands one item to the block. Called at a rising edge; returns at the edge that
  // takes the item. During idle cycles the payload ports carry noise, which the block
  // must not act on since start is low.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start_i    <= 1'b0;
      cmd_i      <= CMD_W'($urandom);
      position_i <= POS_W'($urandom);
      value_i    <= $urandom;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    // busy_o read right after the edge is still the value the block had at that edge.
    do @(posedge clk_i); while (busy_o);
    case (cmd)
      CMD_PUSH: if (list_len < DEPTH) list_len++;
      CMD_POP: if (list_len > 0) list_len--;
      CMD_INSERT: if (list_len < DEPTH && int'(pos) <= list_len) list_len++;
      CMD_REMOVE: if (list_len > 0 && int'(pos) < list_len) list_len--;
      default: begin
      end
    endcase
  endtask

  // Picks one random command. The list is driven up to full and back down to empty
  // in long sweeps, so that full, empty and every length in between are visited with
  // all kinds of commands. Returns 0 for the ignored codes, which do not count.
  task automatic send_random_command(inout bit growing, output bit counted);
    int                       pick;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    if (list_len == DEPTH && $urandom_range(99) < 30) growing = 1'b0;
    if (list_len == 0 && $urandom_range(99) < 50) growing = 1'b1;
    pick = $urandom_range(99);
    if (pick < 3) begin
      cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    end else if (pick < 13) begin
      cmd = CMD_TRAVERSE;
    end else if (pick < 20) begin
      cmd = CMD_REVERSE;
    end else if (pick < (growing ? 75 : 40)) begin
      cmd = $urandom_range(1) ? CMD_PUSH : CMD_INSERT;
    end else begin
      cmd = $urandom_range(1) ? CMD_POP : CMD_REMOVE;
    end
    // Mostly legal positions for the command at hand; the rest covers the whole
    // position field, bad positions included.
    if ($urandom_range(99) < 15) begin
      pos = POS_W'($urandom);
    end else if (cmd == CMD_INSERT) begin
      pos = POS_W'($urandom_range(list_len));
    end else begin
      pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
    end
    case ($urandom_range(9))
      0: val = DATA_MIN;
      1: val = DATA_MAX;
      2: val = DATA_NEG;
      default: val = $urandom;
    endcase
    send_command(cmd, pos, val);
    counted = (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7);
  endtask

  initial begin
    bit growing;
    bit counted;
    int sent;
    int guard;
    int phase_pct[PHASE_COUNT];
    phase_pct = '{0, 83, 0, 29};
    idle_pct  = 0;
    list_len  = 0;
    growing   = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every command but push on an empty list, positions at both ends and
    // beyond, the extreme data words, and the ignored codes.
    send_command(CMD_TRAVERSE, '0, '0);
    send_command(CMD_POP, '0, '0);
    send_command(CMD_REMOVE, '0, '0);
    send_command(CMD_REVERSE, '0, '0);
    send_command(CMD_INSERT, 5'd1, DATA_MAX);     // past the end of an empty list
    send_command(CMD_INSERT, '0, DATA_MIN);       // insert at the head of an empty list
    send_command(CMD_PUSH, POS_MAX, DATA_MAX);
    send_command(CMD_INSERT, 5'd2, DATA_NEG);     // position equal to the length appends
    send_command(CMD_INSERT, POS_MAX, DATA_MAX);  // far beyond the end
    send_command(CMD_REMOVE, 5'd3, '0);           // one past the last entry
    send_command(CMD_REMOVE, POS_MAX, '0);
    send_command(CMD_TRAVERSE, '0, '0);
    send_command(CMD_REVERSE, '0, '0);
    send_command(CMD_TRAVERSE, '0, '0);
    send_command(CMD_REMOVE, 5'd1, '0);
    send_command(CMD_UNUSED_6, 5'd2, DATA_NEG);
    send_command(CMD_UNUSED_7, POS_MAX, DATA_MAX);
    send_command(CMD_INSERT, '0, '0);
    send_command(CMD_REVERSE, '0, '0);
    send_command(CMD_TRAVERSE, '0, '0);
    send_command(CMD_POP, '0, '0);
    send_command(CMD_REMOVE, '0, '0);
    send_command(CMD_POP, '0, '0);
    send_command(CMD_TRAVERSE, '0, '0);

    // Random part, split into phases with different sender idling.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_pct = phase_pct[ph];
      sent = 0;
      while (sent < ITEMS_PER_RUN / PHASE_COUNT) begin
        send_random_command(growing, counted);
        if (counted) sent++;
      end
    end
    start_i <= 1'b0;

    // Drain: a traversal of a full list is the longest train of results. The first
    // edge lets the checker record the final item before its count is read.
    @(posedge clk_i);
    guard = 0;
    while (awaited_count != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("indexed_list_queue verification clean");
    end else begin
      $display("indexed_list_queue verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake; far beyond the slowest correct run.
  initial begin
    #400000;
    $display("indexed_list_queue verification failed");
    $finish;
  end

endmodule

// File: indexed_list_queue.f
+incdir+src
src/ilq_pkg.sv
src/ilq_ctrl.sv
src/ilq_dp.sv
src/indexed_list_queue.sv
src/ilq_checker.sv
test/indexed_list_queue_checker.sv
test/indexed_list_queue_tb.sv
